// ----- rtl/range_min_segment_tree_unit_defines.svh -----
// assertion macros for the range minimum segment tree unit
// used by range_min_segment_tree_unit.sv, no other dependencies
`ifndef RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define RMST_ASSERT_HOLDS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rmst invariant violated");

// consequent must hold whenever antecedent holds
`define RMST_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmst implication violated");

`endif

// ----- rtl/rmst_pkg.sv -----
// types, codes and node helpers for the range minimum segment tree unit
// no dependencies
`default_nettype none

package rmst_pkg;

  localparam int IW = 10;
  localparam int VW = 32;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IW-1:0]          position;
    logic [IW-1:0]          range_high;
    logic signed [VW-1:0]   value;
  } rmst_in_t;

  typedef struct packed {
    logic signed [VW-1:0]   min_value;
    logic [IW-1:0]          min_index;
    logic                   index_valid;
  } rmst_out_t;

  typedef struct packed {
    logic                   ok;
    logic [IW-1:0]          idx;
    logic signed [VW-1:0]   val;
  } rmst_node_t;

  localparam rmst_node_t NODE_NONE = '{ok: 1'b0, idx: '0, val: VAL_MAX};

  // left operand wins ties, a real node beats an empty one
  function automatic rmst_node_t pick(input rmst_node_t a, input rmst_node_t b);
    rmst_node_t res;
    if (!a.ok) begin
      res = b;
    end else if (!b.ok) begin
      res = a;
    end else if ($signed(a.val) <= $signed(b.val)) begin
      res = a;
    end else begin
      res = b;
    end
    return res;
  endfunction

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] sum;
    logic signed [VW-1:0] res;
    sum = {a[VW-1], a} + {b[VW-1], b};
    if (sum[VW] != sum[VW-1]) begin
      res = sum[VW] ? VAL_MIN : VAL_MAX;
    end else begin
      res = sum[VW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/range_min_segment_tree_unit.sv -----
// range minimum segment tree: node memory, sequencer and output register
// depends on rmst_pkg and range_min_segment_tree_unit_defines.svh
//
// input channel in_valid / in_stall / in_data carries set, add and query items;
// output channel out_valid / out_stall / out_data carries one result per query.
// a set or add rewrites one leaf and then one ancestor per cycle, reading the
// sibling through the node memory's first read port. a query walks both range
// ends upward together, one tree level per cycle using both read ports, then
// loads the output register. in_stall is high while an item is in progress;
// the output register lets the next item in while a result waits, and a
// finished query waits until the output register is free.
// kind 3 and updates past the last leaf are taken and dropped.
// after reset the unit builds the tree in memory, one node per cycle,
// writing nodes 1 through 2 * 2^LEVELS - 1, with in_stall high.
// LEAVES may range from 2 to 1024.
`default_nettype none
`include "range_min_segment_tree_unit_defines.svh"

module range_min_segment_tree_unit #(
  parameter int LEAVES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rmst_pkg::rmst_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rmst_pkg::rmst_out_t     out_data
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int AW     = LEVELS + 1;
  localparam int LW     = LEVELS + 2;
  localparam int DEPTH  = 1 << AW;
  localparam int LVW    = $clog2(LEVELS + 2);
  localparam int CW     = rmst_pkg::IW + 1;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_U_LEAF = 3'd2;
  localparam logic [2:0] S_U_RISE = 3'd3;
  localparam logic [2:0] S_Q_RUN  = 3'd4;
  localparam logic [2:0] S_Q_DONE = 3'd5;

  rmst_pkg::rmst_node_t mem [DEPTH];

  logic [2:0]                   state, state_next;
  logic [AW-1:0]                node, node_next;
  rmst_pkg::rmst_node_t         cur, cur_next;
  logic                         add_op, add_op_next;
  logic signed [rmst_pkg::VW-1:0] addend, addend_next;
  logic [LW-1:0]                l, l_next;
  logic [LW-1:0]                r, r_next;
  rmst_pkg::rmst_node_t         left, left_next;
  rmst_pkg::rmst_node_t         right, right_next;
  logic [AW-1:0]                init_addr, init_addr_next;
  logic [LVW-1:0]               init_lvl, init_lvl_next;
  logic                         out_valid_next;
  rmst_pkg::rmst_out_t          out_data_next;

  logic                         we;
  logic [AW-1:0]                waddr;
  rmst_pkg::rmst_node_t         wdata;
  logic [AW-1:0]                rd_a_addr, rd_b_addr;
  rmst_pkg::rmst_node_t         rd_a_data, rd_b_data;

  // helpers for the input item
  logic                         pos_in;
  logic [LEVELS-1:0]            hi_clip;
  logic                         q_nonempty;
  logic [LW-1:0]                q_l_init, q_r_init, q_r_init_m1;
  logic [AW-1:0]                leaf_slot;

  // helpers for one query level
  logic [LW-1:0]                l_step, r_step, l_up, r_up, r_up_m1;
  rmst_pkg::rmst_node_t         left_step, right_step, q_res;

  // helpers for the build pass
  logic [AW-1:0]                init_shift;
  logic [LEVELS-1:0]            init_leaf;
  rmst_pkg::rmst_node_t         init_node;

  // helpers for updates
  rmst_pkg::rmst_node_t         leaf_new, rise_res;
  logic [AW-1:0]                parent;

  always_comb begin
    pos_in    = {1'b0, in_data.position} < CW'(LEAVES);
    if ({1'b0, in_data.range_high} >= CW'(LEAVES)) begin
      hi_clip = LEVELS'(LEAVES - 1);
    end else begin
      hi_clip = in_data.range_high[LEVELS-1:0];
    end
    q_nonempty  = pos_in && ({1'b0, in_data.position} <= CW'(hi_clip));
    leaf_slot   = {1'b1, in_data.position[LEVELS-1:0]};
    if (q_nonempty) begin
      q_l_init = {2'b01, in_data.position[LEVELS-1:0]};
      q_r_init = {2'b01, hi_clip} + LW'(1);
    end else begin
      q_l_init = '0;
      q_r_init = '0;
    end
    q_r_init_m1 = q_r_init - LW'(1);
  end

  always_comb begin
    left_step  = l[0] ? rmst_pkg::pick(left, rd_a_data) : left;
    right_step = r[0] ? rmst_pkg::pick(rd_b_data, right) : right;
    l_step     = l + LW'(l[0]);
    r_step     = r - LW'(r[0]);
    l_up       = l_step >> 1;
    r_up       = r_step >> 1;
    r_up_m1    = r_up - LW'(1);
    q_res      = rmst_pkg::pick(left, right);
  end

  always_comb begin
    init_shift    = init_addr << (LVW'(LEVELS) - init_lvl);
    init_leaf     = init_shift[LEVELS-1:0];
    init_node.ok  = AW'(init_leaf) < AW'(LEAVES);
    init_node.idx = rmst_pkg::IW'(init_leaf);
    init_node.val = rmst_pkg::VAL_MAX;
  end

  always_comb begin
    leaf_new     = rd_a_data;
    leaf_new.val = add_op ? rmst_pkg::sat_add(rd_a_data.val, addend) : addend;
    parent       = node >> 1;
    rise_res     = node[0] ? rmst_pkg::pick(rd_a_data, cur) : rmst_pkg::pick(cur, rd_a_data);
  end

  always_comb begin
    state_next     = state;
    node_next      = node;
    cur_next       = cur;
    add_op_next    = add_op;
    addend_next    = addend;
    l_next         = l;
    r_next         = r;
    left_next      = left;
    right_next     = right;
    init_addr_next = init_addr;
    init_lvl_next  = init_lvl;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = node;
    wdata          = cur;
    rd_a_addr      = '0;
    rd_b_addr      = '0;
    case (state)
      S_INIT: begin
        we             = 1'b1;
        waddr          = init_addr;
        wdata          = init_node;
        init_addr_next = init_addr + AW'(1);
        if ((init_addr & (init_addr + AW'(1))) == '0) begin
          init_lvl_next = init_lvl + LVW'(1);
        end
        if (init_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            rmst_pkg::KIND_SET, rmst_pkg::KIND_ADD: begin
              if (pos_in) begin
                rd_a_addr   = leaf_slot;
                node_next   = leaf_slot;
                add_op_next = in_data.kind == rmst_pkg::KIND_ADD;
                addend_next = in_data.value;
                state_next  = S_U_LEAF;
              end
            end
            rmst_pkg::KIND_QUERY: begin
              rd_a_addr  = q_l_init[AW-1:0];
              rd_b_addr  = q_r_init_m1[AW-1:0];
              l_next     = q_l_init;
              r_next     = q_r_init;
              left_next  = rmst_pkg::NODE_NONE;
              right_next = rmst_pkg::NODE_NONE;
              state_next = S_Q_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      S_U_LEAF: begin
        we         = 1'b1;
        waddr      = node;
        wdata      = leaf_new;
        cur_next   = leaf_new;
        rd_a_addr  = node ^ AW'(1);
        state_next = S_U_RISE;
      end
      S_U_RISE: begin
        we        = 1'b1;
        waddr     = parent;
        wdata     = rise_res;
        cur_next  = rise_res;
        node_next = parent;
        rd_a_addr = parent ^ AW'(1);
        if (parent == AW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_Q_RUN: begin
        if (l < r) begin
          left_next  = left_step;
          right_next = right_step;
          l_next     = l_up;
          r_next     = r_up;
          rd_a_addr  = l_up[AW-1:0];
          rd_b_addr  = r_up_m1[AW-1:0];
        end else begin
          state_next = S_Q_DONE;
        end
      end
      S_Q_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          if (q_res.ok) begin
            out_data_next.min_value   = q_res.val;
            out_data_next.min_index   = q_res.idx;
            out_data_next.index_valid = 1'b1;
          end else begin
            out_data_next.min_value   = rmst_pkg::VAL_MAX;
            out_data_next.min_index   = '0;
            out_data_next.index_valid = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = state != S_IDLE;

  // node memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= AW'(1);
      init_lvl  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_addr <= init_addr_next;
      init_lvl  <= init_lvl_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    node     <= node_next;
    cur      <= cur_next;
    add_op   <= add_op_next;
    addend   <= addend_next;
    l        <= l_next;
    r        <= r_next;
    left     <= left_next;
    right    <= right_next;
    out_data <= out_data_next;
  end

  `RMST_ASSERT_IMPLIES(a_rise_below_root, clk, rst, state == S_U_RISE, node != AW'(1))
  `RMST_ASSERT_IMPLIES(a_query_bounds, clk, rst, state == S_Q_RUN, l <= r)
  `RMST_ASSERT_IMPLIES(a_empty_result, clk, rst, out_valid && !out_data.index_valid, out_data.min_value == rmst_pkg::VAL_MAX)

endmodule

`default_nettype wire

// ----- verif/range_min_segment_tree_unit_test.sv -----
// testbench for range_min_segment_tree_unit: directed and random set, add, query and kind 3 transfers
// a scoreboard class keeps a flat copy of the leaves and predicts each query result
// depends on rmst_pkg and the range_min_segment_tree_unit rtl
`timescale 1ns / 1ps

module range_min_segment_tree_unit_test;

  localparam int LEAF_COUNT = 1024;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  class min_tree_board;
    logic signed [rmst_pkg::VW-1:0] leaf_val [LEAF_COUNT];
    rmst_pkg::rmst_out_t expected_mins [$];
    int errors;

    function new();
      foreach (leaf_val[i]) leaf_val[i] = rmst_pkg::VAL_MAX;
      errors = 0;
    endfunction

    function rmst_pkg::rmst_out_t range_min(input int lo, input int hi);
      rmst_pkg::rmst_out_t res;
      logic signed [rmst_pkg::VW-1:0] best;
      int best_idx;
      bit found;
      found = 0;
      best = rmst_pkg::VAL_MAX;
      best_idx = 0;
      if (hi >= LEAF_COUNT) hi = LEAF_COUNT - 1;
      for (int i = lo; i <= hi && lo < LEAF_COUNT; i++) begin
        if (!found || leaf_val[i] < best) begin
          best = leaf_val[i];
          best_idx = i;
          found = 1;
        end
      end
      res.min_value = best;
      res.min_index = found ? rmst_pkg::IW'(best_idx) : '0;
      res.index_valid = found;
      return res;
    endfunction

    function void note_input(input rmst_pkg::rmst_in_t it);
      longint sum;
      int p;
      p = int'(it.position);
      case (it.kind)
        rmst_pkg::KIND_SET: begin
          if (p < LEAF_COUNT) leaf_val[p] = it.value;
        end
        rmst_pkg::KIND_ADD: begin
          if (p < LEAF_COUNT) begin
            sum = longint'($signed(leaf_val[p])) + longint'($signed(it.value));
            if (sum > longint'(rmst_pkg::VAL_MAX)) sum = longint'(rmst_pkg::VAL_MAX);
            if (sum < longint'(rmst_pkg::VAL_MIN)) sum = longint'(rmst_pkg::VAL_MIN);
            leaf_val[p] = rmst_pkg::VW'(sum);
          end
        end
        rmst_pkg::KIND_QUERY: begin
          expected_mins.push_back(range_min(p, int'(it.range_high)));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(input rmst_pkg::rmst_out_t got);
      rmst_pkg::rmst_out_t want;
      if (expected_mins.size() == 0) begin
        errors++;
        $error("unexpected result transfer: min_value %0d min_index %0d index_valid %0d",
               $signed(got.min_value), got.min_index, got.index_valid);
        return;
      end
      want = expected_mins.pop_front();
      if (got.min_value !== want.min_value) begin
        errors++;
        $error("min_value: expected %0d, got %0d", $signed(want.min_value),
               $signed(got.min_value));
      end
      if (got.min_index !== want.min_index) begin
        errors++;
        $error("min_index: expected %0d, got %0d", want.min_index, got.min_index);
      end
      if (got.index_valid !== want.index_valid) begin
        errors++;
        $error("index_valid: expected %0d, got %0d", want.index_valid, got.index_valid);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  rmst_pkg::rmst_in_t in_data;
  logic out_valid;
  logic out_stall;
  rmst_pkg::rmst_out_t out_data;

  min_tree_board board = new();
  int cycle_count = 0;
  bit sender_idles = 1;
  bit receiver_idles = 1;
  bit hold_off_req = 0;

  range_min_segment_tree_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** range_min_segment_tree_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  function automatic rmst_pkg::rmst_in_t make_item(input logic [1:0] kind, input int pos,
                                                   input int hi,
                                                   input logic signed [rmst_pkg::VW-1:0] val);
    rmst_pkg::rmst_in_t it;
    it.kind = kind;
    it.position = rmst_pkg::IW'(pos);
    it.range_high = rmst_pkg::IW'(hi);
    it.value = val;
    return it;
  endfunction

  function automatic rmst_pkg::rmst_in_t random_item();
    rmst_pkg::rmst_in_t it;
    int r;
    int base;
    int span;
    int lo;
    int hi;
    int t;
    r = $urandom_range(0, 99);
    it.kind = (r < 35) ? rmst_pkg::KIND_SET :
              (r < 55) ? rmst_pkg::KIND_ADD :
              (r < 92) ? rmst_pkg::KIND_QUERY : KIND_SPARE;
    case ($urandom_range(0, 3))
      0, 1: begin base = 0; span = 31; end
      2: begin base = 0; span = LEAF_COUNT - 1; end
      default: begin base = LEAF_COUNT - 32; span = 31; end
    endcase
    lo = base + $urandom_range(0, span);
    hi = base + $urandom_range(0, span);
    if (it.kind == rmst_pkg::KIND_QUERY) begin
      if (lo > hi && $urandom_range(0, 99) < 88) begin
        t = lo;
        lo = hi;
        hi = t;
      end
    end else begin
      hi = $urandom_range(0, LEAF_COUNT - 1);
    end
    it.position = rmst_pkg::IW'(lo);
    it.range_high = rmst_pkg::IW'(hi);
    r = $urandom_range(0, 99);
    if (r < 15) it.value = rmst_pkg::VAL_MAX;
    else if (r < 30) it.value = rmst_pkg::VAL_MIN;
    else if (r < 60) it.value = rmst_pkg::VW'(int'($urandom_range(0, 200)) - 100);
    else it.value = $urandom;
    return it;
  endfunction

  task automatic push_item(input rmst_pkg::rmst_in_t it);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.expected_mins.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random hold-off per result, one long hold-off on request
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold = HOLD_OFF_CYCLES;
        hold_off_req = 0;
      end else begin
        hold = receiver_idles ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: identity, empty ranges, extremes, saturation, ties
    push_item(make_item(rmst_pkg::KIND_QUERY, 0, 1023, 0));
    push_item(make_item(rmst_pkg::KIND_QUERY, 5, 4, 0));
    push_item(make_item(rmst_pkg::KIND_QUERY, 1023, 1023, -1));
    push_item(make_item(rmst_pkg::KIND_SET, 0, 1023, rmst_pkg::VAL_MIN));
    push_item(make_item(rmst_pkg::KIND_SET, 1023, 0, rmst_pkg::VAL_MIN));
    push_item(make_item(rmst_pkg::KIND_QUERY, 0, 1023, 0));
    push_item(make_item(rmst_pkg::KIND_QUERY, 1, 1023, 0));
    push_item(make_item(rmst_pkg::KIND_ADD, 0, 0, -1));
    push_item(make_item(rmst_pkg::KIND_SET, 512, 0, rmst_pkg::VAL_MAX - 1));
    push_item(make_item(rmst_pkg::KIND_ADD, 512, 0, rmst_pkg::VAL_MAX));
    push_item(make_item(rmst_pkg::KIND_QUERY, 512, 512, 0));
    push_item(make_item(rmst_pkg::KIND_ADD, 1023, 0, rmst_pkg::VAL_MAX));
    push_item(make_item(rmst_pkg::KIND_QUERY, 1000, 1023, 0));
    push_item(make_item(rmst_pkg::KIND_SET, 300, 0, 7));
    push_item(make_item(rmst_pkg::KIND_SET, 301, 0, 7));
    push_item(make_item(rmst_pkg::KIND_QUERY, 300, 301, 0));
    push_item(make_item(KIND_SPARE, 1023, 1023, -1));
    push_item(make_item(rmst_pkg::KIND_QUERY, 1023, 0, 0));
    push_item(make_item(rmst_pkg::KIND_QUERY, 1023, 1022, 0));
    push_item(make_item(rmst_pkg::KIND_ADD, 300, 1023, 0));
    push_item(make_item(rmst_pkg::KIND_SET, 700, 1023, 32'sh5555_5555));
    push_item(make_item(rmst_pkg::KIND_QUERY, 0, 0, 0));
    push_item(make_item(rmst_pkg::KIND_SET, 0, 0, rmst_pkg::VAL_MAX));
    push_item(make_item(rmst_pkg::KIND_QUERY, 0, 1022, 0));

    repeat (150) push_item(random_item());

    sender_idles = 0;
    receiver_idles = 0;
    repeat (100) push_item(random_item());

    // long receiver hold-off while queries keep coming back to back
    hold_off_req = 1;
    repeat (30) push_item(make_item(rmst_pkg::KIND_QUERY, $urandom_range(0, 31),
                                    $urandom_range(32, 1023), 0));
    drain_results();

    sender_idles = 1;
    receiver_idles = 1;
    repeat (170) push_item(random_item());
    in_valid <= 1'b0;

    while (board.expected_mins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.expected_mins.size() == 0) begin
      $display("** range_min_segment_tree_unit: PASSED **");
    end else begin
      $display("** range_min_segment_tree_unit: FAILED **");
    end
    $finish;
  end

endmodule
